/* rtl/utcla_pkg.sv */
// package: field widths, calendar constants and helper functions for the utc to local adjust
`default_nettype none
package utcla_pkg;

  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;

  localparam int ZoneHoursW   = 5;
  localparam int ZoneMinutesW = 7;

  localparam int ItemW  = YearW + MonthW + DayW + HourW + MinuteW;
  localparam int TdataW = ((ItemW + 7) / 8) * 8;
  localparam int PadW   = TdataW - ItemW;

  localparam int CfgAddrW = 1;
  localparam int CfgDataW = ZoneMinutesW;

  // register indexes on the config port
  localparam logic [CfgAddrW-1:0] CfgZoneHours   = 1'd0;
  localparam logic [CfgAddrW-1:0] CfgZoneMinutes = 1'd1;

  localparam int MinutesPerHour = 60;
  localparam int HoursPerDay    = 24;
  localparam int MonthsPerYear  = 12;
  localparam int YearMin        = 1;
  localparam int YearMax        = 9999;

  // multiplicative inverse of 25 modulo 2**14 and the divisibility bound
  localparam logic [YearW-1:0] YearInv25   = 14'd7209;
  localparam logic [YearW-1:0] YearDiv25Lo = 14'd655;

  // gregorian leap year: (div4 and not div100) or div400
  // div100 = div4 and div25, div400 = div16 and div25
  function automatic logic is_leap(input logic [YearW-1:0] year);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = year * YearInv25;
    div25 = (prod <= YearDiv25Lo);
    return ((year[1:0] == 2'd0) && !div25) || ((year[3:0] == 4'd0) && div25);
  endfunction

  // days in month, months outside 1..12 count as 31 days
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

/* rtl/utc_to_local_date_adjust_top.sv */
// top level: utc calendar time to local time with a configurable zone offset
// stages: the input register takes each input transfer, and the result register, which
//   drives out_tvalid, takes the converted item from it when it can load
// throughput: one item per cycle; the input register and result register each
//   hold one item, so in_tready stays high while out_tready is high
// reset: synchronous active-low rst_n empties both stages and clears the zone
//   offset registers to zero hours and zero minutes
`default_nettype none
module utc_to_local_date_adjust_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // config write port
  input  wire logic                            cfg_we,
  input  wire logic [utcla_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [utcla_pkg::CfgDataW-1:0]  cfg_wdata,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata: year_in, month_in, day_in, hour_in, minute_in, zero pad
  input  wire logic [utcla_pkg::TdataW-1:0]    in_tdata,
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // tdata: year_out, month_out, day_out, hour_out, minute_out, zero pad
  output logic [utcla_pkg::TdataW-1:0]         out_tdata
);
  import utcla_pkg::*;

  // bit offsets of the fields in tdata
  localparam int MonthLsb  = YearW;
  localparam int DayLsb    = MonthLsb + MonthW;
  localparam int HourLsb   = DayLsb + DayW;
  localparam int MinuteLsb = HourLsb + HourW;

  // ---------------------------------------------------------------------------
  // zone offset registers
  // ---------------------------------------------------------------------------
  logic signed [ZoneHoursW-1:0]   zone_hours_r;
  logic signed [ZoneMinutesW-1:0] zone_minutes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_hours_r   <= '0;
      zone_minutes_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CfgZoneHours:   zone_hours_r   <= cfg_wdata[ZoneHoursW-1:0];
        CfgZoneMinutes: zone_minutes_r <= cfg_wdata[ZoneMinutesW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: each stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic s1_vld_r;
  logic out_vld_r;
  logic out_load;

  assign out_load  = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) s1_vld_r  <= in_tvalid;
      if (out_load)  out_vld_r <= s1_vld_r;
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic [YearW-1:0]   year_r;
  logic [MonthW-1:0]  month_r;
  logic [DayW-1:0]    day_r;
  logic [HourW-1:0]   hour_r;
  logic [MinuteW-1:0] minute_r;

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      year_r   <= in_tdata[MonthLsb-1:0];
      month_r  <= in_tdata[DayLsb-1:MonthLsb];
      day_r    <= in_tdata[HourLsb-1:DayLsb];
      hour_r   <= in_tdata[MinuteLsb-1:HourLsb];
      minute_r <= in_tdata[ItemW-1:MinuteLsb];
    end
  end

  // ---------------------------------------------------------------------------
  // conversion: minute carry, hour carry, day roll, month roll, year clamp
  // ---------------------------------------------------------------------------
  logic              leap;
  logic signed [7:0] min_sum;
  logic signed [7:0] min_fix;
  logic signed [6:0] hour_c;
  logic signed [6:0] hour_sum;
  logic signed [6:0] hour_fix;
  logic signed [6:0] day_c;
  logic signed [6:0] day_fix;
  logic signed [5:0] month_c;
  logic signed [5:0] month_fix;
  logic signed [15:0] year_c;
  logic signed [15:0] year_fix;
  logic [DayW-1:0]   len_cur;
  logic [DayW-1:0]   len_prev;
  logic              day_over;
  logic              day_under;

  logic [YearW-1:0]   year_nxt;
  logic [MonthW-1:0]  month_nxt;
  logic [DayW-1:0]    day_nxt;
  logic [HourW-1:0]   hour_nxt;
  logic [MinuteW-1:0] minute_nxt;

  assign leap = is_leap(year_r);

  always_comb begin
    // minute offset, one carry into the hour
    min_sum = $signed({2'b00, minute_r}) + 8'(zone_minutes_r);
    hour_c  = $signed({2'b00, hour_r});
    min_fix = min_sum;
    if (min_sum >= 8'(MinutesPerHour)) begin
      min_fix = min_sum - 8'(MinutesPerHour);
      hour_c  = hour_c + 7'sd1;
    end else if (min_sum < 8'sd0) begin
      min_fix = min_sum + 8'(MinutesPerHour);
      hour_c  = hour_c - 7'sd1;
    end

    // hour offset, one carry into the day
    hour_sum = hour_c + 7'(zone_hours_r);
    day_c    = $signed({2'b00, day_r});
    hour_fix = hour_sum;
    if (hour_sum >= 7'(HoursPerDay)) begin
      hour_fix = hour_sum - 7'(HoursPerDay);
      day_c    = day_c + 7'sd1;
    end else if (hour_sum < 7'sd0) begin
      hour_fix = hour_sum + 7'(HoursPerDay);
      day_c    = day_c - 7'sd1;
    end

    // day roll against the month length of the input year
    len_cur   = month_len(month_r, leap);
    len_prev  = (month_r > 4'd1) ? month_len(month_r - 4'd1, leap)
                                 : month_len(4'(MonthsPerYear), leap);
    day_over  = (day_c > $signed({2'b00, len_cur}));
    day_under = (day_c < 7'sd1);
    month_c   = $signed({2'b00, month_r});
    day_fix   = day_c;
    if (day_over) begin
      day_fix = 7'sd1;
      month_c = month_c + 6'sd1;
    end else if (day_under) begin
      day_fix = $signed({2'b00, len_prev});
      month_c = month_c - 6'sd1;
    end

    // month roll into the year
    year_c    = $signed({2'b00, year_r});
    month_fix = month_c;
    if (month_c > 6'(MonthsPerYear)) begin
      month_fix = 6'sd1;
      year_c    = year_c + 16'sd1;
    end else if (month_c < 6'sd1) begin
      month_fix = 6'(MonthsPerYear);
      year_c    = year_c - 16'sd1;
    end

    // year saturates at the range ends
    year_fix = year_c;
    if (year_c < 16'(YearMin)) year_fix = 16'(YearMin);
    if (year_c > 16'(YearMax)) year_fix = 16'(YearMax);

    year_nxt   = year_fix[YearW-1:0];
    month_nxt  = month_fix[MonthW-1:0];
    day_nxt    = day_fix[DayW-1:0];
    hour_nxt   = hour_fix[HourW-1:0];
    minute_nxt = min_fix[MinuteW-1:0];
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic [YearW-1:0]   year_out_r;
  logic [MonthW-1:0]  month_out_r;
  logic [DayW-1:0]    day_out_r;
  logic [HourW-1:0]   hour_out_r;
  logic [MinuteW-1:0] minute_out_r;

  always_ff @(posedge clk) begin
    if (out_load && s1_vld_r) begin
      year_out_r   <= year_nxt;
      month_out_r  <= month_nxt;
      day_out_r    <= day_nxt;
      hour_out_r   <= hour_nxt;
      minute_out_r <= minute_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PadW{1'b0}}, minute_out_r, hour_out_r, day_out_r,
                       month_out_r, year_out_r};

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_load |=> out_vld_r)
    else $error("input stage item did not reach the result register");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_tready)
    else $error("in_tready low with an empty input stage");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (month_out_r >= 4'd1) && (month_out_r <= 4'(MonthsPerYear)))
    else $error("month_out outside 1..12");

  a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (day_out_r != '0))
    else $error("day_out is zero");

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (year_out_r >= 14'(YearMin)) && (year_out_r <= 14'(YearMax)))
    else $error("year_out outside the clamp range");

endmodule
`default_nettype wire

/* bench/tb.sv */
// testbench: utc to local time adjust, streamed timestamps checked against a calendar predictor
`timescale 1ns / 1ps
module tb;
  import utcla_pkg::*;

  // one timestamp as it sits in tdata, year in the lowest bits
  typedef struct packed {
    logic [MinuteW-1:0] minute;
    logic [HourW-1:0]   hour;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
  } stamp_t;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 215;
  localparam int StallCycles = 300;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  // tdata: year_in, month_in, day_in, hour_in, minute_in, zero pad
  logic [TdataW-1:0]   in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  // tdata: year_out, month_out, day_out, hour_out, minute_out, zero pad
  logic [TdataW-1:0]   out_tdata;

  utc_to_local_date_adjust_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // zone offset as the block holds it, sign-extended from the register width
  int zone_hr;
  int zone_min;

  stamp_t utc_backlog_q[$];  // timestamps waiting for the driver
  stamp_t local_due_q[$];    // predicted local times, oldest first

  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  // receiver hold-off requests; the monitor counts the stall itself
  int hold_requests;
  int hold_served;
  int hold_left;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // calendar predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_leap_year(input int yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // month length; anything outside 1..12 counts as a 31 day month
  function automatic int days_in(input int mon, input bit leap);
    case (mon)
      2:              return leap ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  // shift one utc stamp by the zone offset, one carry step per level
  function automatic stamp_t predict_local(input stamp_t utc);
    int     yr;
    int     mon;
    int     dy;
    int     hr;
    int     mn;
    bit     leap;
    stamp_t loc;
    yr   = utc.year;
    mon  = utc.month;
    dy   = utc.day;
    hr   = utc.hour;
    mn   = utc.minute;
    // february length always follows the input year
    leap = is_leap_year(yr);

    mn += zone_min;
    if (mn >= MinutesPerHour) begin
      mn -= MinutesPerHour;
      hr += 1;
    end else if (mn < 0) begin
      mn += MinutesPerHour;
      hr -= 1;
    end

    hr += zone_hr;
    if (hr >= HoursPerDay) begin
      hr -= HoursPerDay;
      dy += 1;
    end else if (hr < 0) begin
      hr += HoursPerDay;
      dy -= 1;
    end

    if (dy > days_in(mon, leap)) begin
      dy = 1;
      mon += 1;
    end else if (dy < 1) begin
      // borrow lands on the last day of the month before
      dy = (mon > 1) ? days_in(mon - 1, leap) : days_in(MonthsPerYear, leap);
      mon -= 1;
    end

    if (mon > MonthsPerYear) begin
      mon = 1;
      yr += 1;
    end else if (mon < 1) begin
      mon = MonthsPerYear;
      yr -= 1;
    end

    if (yr < YearMin) yr = YearMin;
    if (yr > YearMax) yr = YearMax;

    // leftover hour or minute overflow wraps to the field width
    loc.year   = yr[YearW-1:0];
    loc.month  = mon[MonthW-1:0];
    loc.day    = dy[DayW-1:0];
    loc.hour   = hr[HourW-1:0];
    loc.minute = mn[MinuteW-1:0];
    return loc;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stamp_t mk_stamp(input int yr, input int mon, input int dy,
                                      input int hr, input int mn);
    stamp_t s;
    s.year   = yr[YearW-1:0];
    s.month  = mon[MonthW-1:0];
    s.day    = dy[DayW-1:0];
    s.hour   = hr[HourW-1:0];
    s.minute = mn[MinuteW-1:0];
    return s;
  endfunction

  // mostly valid timestamps leaning on month, day and year edges, some raw noise
  function automatic stamp_t random_stamp();
    stamp_t s;
    int     yr;
    int     mon;
    int     len;
    int     dy;
    int     hr;
    int     mn;
    if ($urandom_range(99) < 12) begin
      s.year   = YearW'($urandom);
      s.month  = MonthW'($urandom);
      s.day    = DayW'($urandom);
      s.hour   = HourW'($urandom);
      s.minute = MinuteW'($urandom);
      return s;
    end
    case ($urandom_range(5))
      0:       yr = YearMin;
      1:       yr = YearMax;
      2:       yr = 4 * $urandom_range(1, 2499);
      3:       yr = 100 * $urandom_range(1, 99);
      default: yr = $urandom_range(YearMin, YearMax);
    endcase
    mon = $urandom_range(1, MonthsPerYear);
    len = days_in(mon, is_leap_year(yr));
    case ($urandom_range(3))
      0:       dy = 1;
      1:       dy = len;
      2:       dy = len - 1;
      default: dy = $urandom_range(1, len);
    endcase
    case ($urandom_range(3))
      0:       hr = 0;
      1:       hr = HoursPerDay - 1;
      default: hr = $urandom_range(0, HoursPerDay - 1);
    endcase
    case ($urandom_range(3))
      0:       mn = 0;
      1:       mn = MinutesPerHour - 1;
      default: mn = $urandom_range(0, MinutesPerHour - 1);
    endcase
    return mk_stamp(yr, mon, dy, hr, mn);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void cmp_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_local(input logic [TdataW-1:0] word);
    stamp_t got;
    stamp_t want;
    got = word[ItemW-1:0];
    if (local_due_q.size() == 0) begin
      $display("%0t: result with nothing expected: expected none, actual %p", $time, got);
      mismatches++;
      return;
    end
    want = local_due_q.pop_front();
    cmp_field("year", 16'(want.year), 16'(got.year));
    cmp_field("month", 16'(want.month), 16'(got.month));
    cmp_field("day", 16'(want.day), 16'(got.day));
    cmp_field("hour", 16'(want.hour), 16'(got.hour));
    cmp_field("minute", 16'(want.minute), 16'(got.minute));
    cmp_field("pad", '0, 16'(word[TdataW-1:ItemW]));
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued timestamps, predicts each one on its transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // the stamp on the bus was taken at this edge
      if (in_tvalid && in_tready) local_due_q.push_back(predict_local(in_tdata[ItemW-1:0]));
      if (!in_tvalid || in_tready) begin
        if (utc_backlog_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= {{PadW{1'b0}}, utc_backlog_q.pop_front()};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random backpressure plus long hold-offs on request
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else begin
      if (out_tvalid && out_tready) check_local(out_tdata);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left  <= StallCycles;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------------

  // wait until the sender is empty and every predicted result has come back,
  // then give the two stage pipeline a few spare cycles
  task automatic wait_drained();
    do @(negedge clk);
    while (utc_backlog_q.size() != 0 || in_tvalid || local_due_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // both registers, only while the block holds nothing
  task automatic write_zone(input int zh, input int zm);
    logic signed [ZoneHoursW-1:0]   zh_bits;
    logic signed [ZoneMinutesW-1:0] zm_bits;
    zh_bits = zh[ZoneHoursW-1:0];
    zm_bits = zm[ZoneMinutesW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CfgZoneHours;
    cfg_wdata <= CfgDataW'(zh);
    @(posedge clk);
    cfg_addr  <= CfgZoneMinutes;
    cfg_wdata <= CfgDataW'(zm);
    @(posedge clk);
    cfg_we    <= 1'b0;
    zone_hr  = zh_bits;
    zone_min = zm_bits;
  endtask

  task automatic queue_random(input int n);
    repeat (n) utc_backlog_q.push_back(random_stamp());
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    zone_hr       = 0;
    zone_min      = 0;
    mismatches    = 0;
    cycles        = 0;
    hold_requests = 0;
    hold_served   = 0;
    hold_left     = 0;
    send_idle_pct = 36;
    recv_idle_pct = 36;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, zero offset out of reset: field extremes
    utc_backlog_q.push_back(mk_stamp(0, 1, 1, 0, 0));          // year zero clamps up
    utc_backlog_q.push_back(mk_stamp(16383, 15, 31, 31, 63));  // every input bit set
    utc_backlog_q.push_back(mk_stamp(2024, 6, 15, 12, 30));
    wait_drained();

    // eastward offset: forward carries
    write_zone(14, 59);
    utc_backlog_q.push_back(mk_stamp(9999, 12, 31, 23, 30));   // year clamps at the top
    utc_backlog_q.push_back(mk_stamp(2024, 2, 28, 10, 1));     // leap february 29th
    utc_backlog_q.push_back(mk_stamp(1900, 2, 28, 12, 0));     // century, not leap
    utc_backlog_q.push_back(mk_stamp(2000, 2, 28, 12, 0));     // 400 year leap
    utc_backlog_q.push_back(mk_stamp(2023, 12, 31, 12, 0));    // new year
    utc_backlog_q.push_back(mk_stamp(2023, 15, 31, 12, 0));    // month past twelve
    utc_backlog_q.push_back(mk_stamp(2023, 4, 30, 23, 59));
    utc_backlog_q.push_back(mk_stamp(2023, 1, 5, 31, 63));     // hour and minute overrange
    wait_drained();

    // westward offset: borrows
    write_zone(-12, -59);
    utc_backlog_q.push_back(mk_stamp(1, 1, 1, 0, 0));          // year clamps at the bottom
    utc_backlog_q.push_back(mk_stamp(2024, 3, 1, 5, 0));
    utc_backlog_q.push_back(mk_stamp(2100, 3, 1, 5, 0));
    utc_backlog_q.push_back(mk_stamp(2023, 5, 0, 20, 30));     // day zero
    utc_backlog_q.push_back(mk_stamp(2023, 0, 1, 3, 0));       // month zero with borrow
    utc_backlog_q.push_back(mk_stamp(2023, 13, 1, 3, 0));
    utc_backlog_q.push_back(mk_stamp(2023, 0, 31, 20, 0));     // month zero, no borrow
    utc_backlog_q.push_back(mk_stamp(2023, 1, 1, 0, 0));
    wait_drained();

    // random: back to back with no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_zone(5, 30);
    queue_random(PhaseItems);
    wait_drained();

    // receiver holds off while the sender keeps offering, so in_tready drops
    write_zone(-16, -64);
    queue_random(PhaseItems);
    hold_requests++;
    wait_drained();

    send_idle_pct = 36;
    recv_idle_pct = 36;
    write_zone(15, 63);
    queue_random(PhaseItems);
    wait_drained();

    write_zone(0, 59);
    queue_random(PhaseItems);
    wait_drained();

    write_zone(0, -59);
    queue_random(PhaseItems);
    wait_drained();

    write_zone(14, -30);
    queue_random(PhaseItems);
    wait_drained();

    repeat (3) begin
      write_zone(int'($urandom_range(0, 26)) - 12, int'($urandom_range(0, 118)) - 59);
      queue_random(PhaseItems);
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (local_due_q.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0", $time, local_due_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
